/* src/lzwd_pkg.sv */
// Shared types, constants and helpers for the LZW code decoder.
// No dependencies; compile first.
package lzwd_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int CODE_W        = MAX_CODE_BITS;
    localparam int NFC_W         = MAX_CODE_BITS + 1;
    localparam int STACK_AW      = 9;
    localparam int EXT_W         = 3;

    localparam logic [STACK_AW-1:0] STACK_DEPTH = 9'd511;
    localparam logic [NFC_W-1:0]    FIRST_FREE  = 13'd256;
    localparam logic [CODE_W-1:0]   LIT_MAX     = 12'd255;
    localparam logic [3:0]          BYTES_PER_WORD = 4'd8;
    localparam logic [EXT_W-1:0]    EXT_RESET   = 3'd4;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_END      = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIRST,
        ST_POP,
        ST_EMIT
    } lzwd_state_t;

    function automatic logic [CODE_W-1:0] end_code_f(input logic [EXT_W-1:0] ext);
        logic [CODE_W-1:0] res;
        case (ext)
            3'd0, 3'd1: res = 12'h1FF;
            3'd2:       res = 12'h3FF;
            3'd3:       res = 12'h7FF;
            default:    res = 12'hFFF;
        endcase
        return res;
    endfunction

endpackage

/* src/lzwd_if.sv */
// Valid/ready channel interfaces for code requests and byte results.
// Depends on lzwd_pkg.
interface lzwd_code_if;
    import lzwd_pkg::*;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code;
    logic              block_start;

    modport source (output valid, output code, output block_start, input ready);
    modport sink   (input valid, input code, input block_start, output ready);
endinterface

interface lzwd_byte_if;
    logic        valid;
    logic        ready;
    logic [63:0] bytes;
    logic [3:0]  byte_count;
    logic        last;
    logic [1:0]  status;

    modport source (output valid, output bytes, output byte_count, output last,
                    output status, input ready);
    modport sink   (input valid, input bytes, input byte_count, input last,
                    input status, output ready);
endinterface

/* src/lzw_code_decoder.sv */
// LZW code decoder top level: sequencer, string stack and output register.
// Depends on lzwd_pkg, lzwd_if and lzwd_dict.
// An n-byte string is walked with a table read per byte onto the stack, then read back
//   with a stack read per byte; results leave in words of up to 8 bytes.
// Handshake: one code at a time, ready when idle.
// Reset: async active low; width register 4, next free code 256, tables undefined.
module lzw_code_decoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lzwd_pkg::EXT_W-1:0]  cfg_wdata,
    lzwd_code_if.sink                   item,
    lzwd_byte_if.source                 result
);
    import lzwd_pkg::*;

    lzwd_state_t state_reg, state_next;

    logic [EXT_W-1:0]    ext_reg;
    logic [NFC_W-1:0]    nfc_reg, nfc_next;
    logic [CODE_W-1:0]   prev_reg, prev_next;
    logic [7:0]          pfb_reg, pfb_next;
    logic                ended_reg, ended_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [CODE_W-1:0]   c_reg, c_next;
    logic [STACK_AW-1:0] sp_reg, sp_next;
    logic [63:0]         word_reg, word_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic [1:0]          status_reg, status_next;
    logic                last_reg, last_next;

    logic                out_valid_reg;
    logic [63:0]         out_bytes_reg;
    logic [3:0]          out_count_reg;
    logic                out_last_reg;
    logic [1:0]          out_status_reg;
    logic                out_load;
    logic                out_free;

    logic [CODE_W-1:0]   end_code;
    logic [CODE_W-1:0]   masked;
    logic                accept;

    logic                dict_we;
    logic [CODE_W-1:0]   pfx_rd;
    logic [7:0]          sfx_rd;

    logic [7:0]          stack_mem [2**STACK_AW];
    logic                stk_we;
    logic [STACK_AW-1:0] stk_waddr;
    logic [7:0]          stk_wdata;
    logic [STACK_AW-1:0] stk_raddr;
    logic [7:0]          stk_rd_reg;
    logic [7:0]          push_byte;

    assign end_code = end_code_f(ext_reg);
    assign masked   = item.code & end_code;
    assign accept   = item.valid && item.ready;
    assign item.ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || result.ready;

    lzwd_dict u_dict (
        .clk     (clk),
        .we      (dict_we),
        .waddr   (nfc_reg[CODE_W-1:0]),
        .wprefix (prev_reg),
        .wsuffix (c_reg[7:0]),
        .raddr   (c_next),
        .rprefix (pfx_rd),
        .rsuffix (sfx_rd)
    );

    assign stk_raddr = sp_next - 1'b1;

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        stk_rd_reg <= stack_mem[stk_raddr];
    end

    always_comb
    begin
        push_byte = stk_rd_reg;
        word_next = word_reg;
        for (int i = 0; i < 8; i++)
        begin
            if (cnt_reg[2:0] == i[2:0])
            begin
                word_next[i*8 +: 8] = push_byte;
            end
        end

        state_next  = state_reg;
        nfc_next    = nfc_reg;
        prev_next   = prev_reg;
        pfb_next    = pfb_reg;
        ended_next  = ended_reg;
        code_next   = code_reg;
        c_next      = c_reg;
        sp_next     = sp_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        last_next   = last_reg;
        dict_we     = 1'b0;
        stk_we      = 1'b0;
        stk_waddr   = sp_reg;
        stk_wdata   = sfx_rd;
        out_load    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                word_next = word_reg;
                if (accept)
                begin
                    word_next   = '0;
                    status_next = STAT_OK;
                    last_next   = 1'b1;
                    code_next   = masked;
                    if (item.block_start)
                    begin
                        word_next[7:0] = masked[7:0];
                        cnt_next   = 4'd1;
                        nfc_next   = FIRST_FREE;
                        prev_next  = {{(CODE_W-8){1'b0}}, masked[7:0]};
                        pfb_next   = masked[7:0];
                        ended_next = 1'b0;
                        state_next = ST_EMIT;
                    end
                    else if (ended_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (masked == end_code)
                    begin
                        cnt_next    = 4'd0;
                        status_next = STAT_END;
                        ended_next  = 1'b1;
                        state_next  = ST_EMIT;
                    end
                    else
                    begin
                        cnt_next = 4'd0;
                        if (masked > LIT_MAX && {1'b0, masked} >= nfc_reg)
                        begin
                            stk_we    = 1'b1;
                            stk_waddr = '0;
                            stk_wdata = pfb_reg;
                            sp_next   = 9'd1;
                            c_next    = prev_reg;
                        end
                        else
                        begin
                            sp_next = '0;
                            c_next  = masked;
                        end
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                word_next = word_reg;
                if (c_reg > LIT_MAX)
                begin
                    if (sp_reg >= STACK_DEPTH)
                    begin
                        status_next = STAT_OVERFLOW;
                        state_next  = ST_FIRST;
                    end
                    else
                    begin
                        stk_we  = 1'b1;
                        sp_next = sp_reg + 1'b1;
                        c_next  = pfx_rd;
                    end
                end
                else
                begin
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                word_next      = '0;
                word_next[7:0] = c_reg[7:0];
                cnt_next       = 4'd1;
                if (nfc_reg < {1'b0, end_code})
                begin
                    dict_we  = 1'b1;
                    nfc_next = nfc_reg + 1'b1;
                end
                prev_next = code_reg;
                pfb_next  = c_reg[7:0];
                if (sp_reg == '0)
                begin
                    last_next  = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                sp_next  = sp_reg - 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (sp_next == '0)
                begin
                    last_next  = 1'b1;
                    state_next = ST_EMIT;
                end
                else if (cnt_next == BYTES_PER_WORD)
                begin
                    last_next  = 1'b0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                word_next = word_reg;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    word_next  = '0;
                    cnt_next   = 4'd0;
                    state_next = last_reg ? ST_IDLE : ST_POP;
                end
            end
            default:
            begin
                word_next  = word_reg;
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ext_reg       <= EXT_RESET;
            nfc_reg       <= FIRST_FREE;
            prev_reg      <= '0;
            pfb_reg       <= '0;
            ended_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            nfc_reg   <= nfc_next;
            prev_reg  <= prev_next;
            pfb_reg   <= pfb_next;
            ended_reg <= ended_next;
            if (cfg_we)
            begin
                ext_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg   <= code_next;
        c_reg      <= c_next;
        sp_reg     <= sp_next;
        word_reg   <= word_next;
        cnt_reg    <= cnt_next;
        status_reg <= status_next;
        last_reg   <= last_next;
        if (out_load)
        begin
            out_bytes_reg  <= word_reg;
            out_count_reg  <= cnt_reg;
            out_last_reg   <= last_reg;
            out_status_reg <= status_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.bytes      = out_bytes_reg;
    assign result.byte_count = out_count_reg;
    assign result.last       = out_last_reg;
    assign result.status     = out_status_reg;

endmodule

/* src/lzwd_dict.sv */
// Dictionary memory: prefix and suffix tables, one write and one registered read.
// Depends on lzwd_pkg.
module lzwd_dict (
    input  logic                        clk,
    input  logic                        we,
    input  logic [lzwd_pkg::CODE_W-1:0] waddr,
    input  logic [lzwd_pkg::CODE_W-1:0] wprefix,
    input  logic [7:0]                  wsuffix,
    input  logic [lzwd_pkg::CODE_W-1:0] raddr,
    output logic [lzwd_pkg::CODE_W-1:0] rprefix,
    output logic [7:0]                  rsuffix
);
    import lzwd_pkg::*;

    logic [CODE_W-1:0] prefix_mem [2**CODE_W];
    logic [7:0]        suffix_mem [2**CODE_W];
    logic [CODE_W-1:0] rprefix_reg;
    logic [7:0]        rsuffix_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            prefix_mem[waddr] <= wprefix;
            suffix_mem[waddr] <= wsuffix;
        end
        rprefix_reg <= prefix_mem[raddr];
        rsuffix_reg <= suffix_mem[raddr];
    end

    assign rprefix = rprefix_reg;
    assign rsuffix = rsuffix_reg;

endmodule

/* src/lzwd_checker.sv */
// Port-level checks for the LZW code decoder, bound to the top level.
// Depends on lzwd_pkg and lzw_code_decoder.
module lzwd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [63:0] res_bytes,
    input logic [3:0]  res_count,
    input logic        res_last,
    input logic [1:0]  res_status
);
    import lzwd_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_bytes) && $stable(res_count))
        else $error("result request dropped or changed while stalled");

    a_end_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == STAT_END |-> res_count == 4'd0 && res_last)
        else $error("end result carries bytes or is not last");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status != STAT_END |-> res_count != 4'd0 && res_count <= 4'd8)
        else $error("byte count out of range");

    a_full_unless_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_last |-> res_count == BYTES_PER_WORD)
        else $error("non-final result not full");

endmodule

bind lzw_code_decoder lzwd_checker u_lzwd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_bytes  (result.bytes),
    .res_count  (result.byte_count),
    .res_last   (result.last),
    .res_status (result.status)
);
